@@ design/clock_buffer_pool_manager_top_macros.svh @@
// Assertion macros shared by the buffer pool manager RTL.
`ifndef CLOCK_BUFFER_POOL_MANAGER_TOP_MACROS_SVH
`define CLOCK_BUFFER_POOL_MANAGER_TOP_MACROS_SVH
`ifndef ASSERT_OFF
`define CBPM_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("assertion failed");
`define CBPM_NEVER(lbl, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) \
        else $error("forbidden condition seen");
`else
`define CBPM_ASSERT(lbl, prop)
`define CBPM_NEVER(lbl, cond)
`endif
`endif

@@ design/cbpm_pkg.sv @@
// Types and codes of the buffer pool manager.
package cbpm_pkg;
    typedef struct packed {
        logic [1:0]  cmd;
        logic [3:0]  tbl_id;
        logic [31:0] page_addr;
        logic [3:0]  frame_index;
        logic        mark_dirty;
    } t_in_word;

    typedef struct packed {
        logic [2:0]  kind;
        logic [3:0]  frame;
        logic [3:0]  wb_table;
        logic [31:0] wb_page;
        logic        last;
    } t_out_word;

    localparam logic [1:0] CMD_PIN   = 2'd0;
    localparam logic [1:0] CMD_UNPIN = 2'd1;
    localparam logic [1:0] CMD_CLOSE = 2'd2;

    localparam logic [2:0] K_HIT      = 3'd0;
    localparam logic [2:0] K_LOADED   = 3'd1;
    localparam logic [2:0] K_WB       = 3'd2;
    localparam logic [2:0] K_UNPIN    = 3'd3;
    localparam logic [2:0] K_CLOSED   = 3'd4;
    localparam logic [2:0] K_NOVICTIM = 3'd5;
    localparam logic [2:0] K_ERR      = 3'd6;
endpackage

@@ design/cbpm_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module cbpm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

@@ design/clock_buffer_pool_manager_top.sv @@
// Clock (second-chance) buffer pool tag manager: top level.
// A pin scans frames from index 0 until a hit; on a miss it sweeps at most twice the sweep
// size of frames from the hand. A close visits every frame. Each frame visit is a read state
// and an evaluate state; output stalls can hold the evaluate state.
// One request at a time: the next is accepted at the edge after its final word is loaded.
// Reset (synchronous, active low) empties all frames at once through valid flops.
module clock_buffer_pool_manager_top
    import cbpm_pkg::*;
#(
    parameter int NUM_FRAMES = 16,
    parameter int NUM_TABLES = 16,
    parameter int PIN_BITS   = 8
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_word  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_word o_out_data,
    input  logic      i_cfg_valid,
    output logic      o_cfg_ready,
    input  logic [4:0] i_cfg_data
);
`include "clock_buffer_pool_manager_top_macros.svh"

    localparam int FW  = $clog2(NUM_FRAMES);
    localparam int CW  = $clog2(NUM_FRAMES + 1);
    localparam int CFW = (CW > 5) ? CW : 5;
    localparam int SW  = $clog2(2 * NUM_FRAMES + 1);
    localparam int EW  = PIN_BITS + 38;

    typedef enum logic [10:0] {
        ST_IDLE  = 11'b00000000001,
        ST_LK_RD = 11'b00000000010,
        ST_LK_EV = 11'b00000000100,
        ST_SW_RD = 11'b00000001000,
        ST_SW_EV = 11'b00000010000,
        ST_LOAD  = 11'b00000100000,
        ST_CL_RD = 11'b00001000000,
        ST_CL_EV = 11'b00010000000,
        ST_UN_RD = 11'b00100000000,
        ST_UN_EV = 11'b01000000000,
        ST_RESP  = 11'b10000000000
    } t_state;

    t_state          r_state;
    t_in_word        r_req;
    logic [CFW-1:0]  r_fiu;
    logic [CW-1:0]   r_cap;
    logic [FW-1:0]   r_hand;
    logic [FW-1:0]   r_idx;
    logic [FW-1:0]   r_b;
    logic [FW-1:0]   r_addr;
    logic [SW-1:0]   r_steps;
    logic            r_fv [NUM_FRAMES];
    logic            r_out_valid;
    t_out_word       r_out;
    t_out_word       r_res;

    // frame RAM port
    logic            ram_we;
    logic [FW-1:0]   ram_waddr;
    logic [EW-1:0]   ram_wdata;
    logic            ram_re;
    logic [FW-1:0]   ram_raddr;
    logic [EW-1:0]   ram_q;

    cbpm_ram #(.WIDTH(EW), .DEPTH(NUM_FRAMES)) u_frames (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_q)
    );

    // An empty frame always reads as all zero: mask the RAM word by its valid flop.
    logic [EW-1:0]       rd;
    logic [3:0]          d_table;
    logic [31:0]         d_page;
    logic                d_dirty;
    logic                d_ref;
    logic [PIN_BITS-1:0] d_pins;
    logic                d_valid;

    assign d_valid = r_fv[r_addr];
    assign rd      = d_valid ? ram_q : '0;
    assign d_pins  = rd[PIN_BITS-1:0];
    assign d_ref   = rd[PIN_BITS];
    assign d_dirty = rd[PIN_BITS+1];
    assign d_page  = rd[PIN_BITS+33:PIN_BITS+2];
    assign d_table = rd[PIN_BITS+37:PIN_BITS+34];

    logic tag_match;
    logic close_hit;
    logic can_emit;
    logic victim_wb;
    logic out_push;
    logic in_eval;
    logic [FW:0] b_inc;
    logic [FW-1:0] b_next;

    assign tag_match = d_valid && (d_table == r_req.tbl_id) && (d_page == r_req.page_addr);
    assign close_hit = d_valid && (d_table == r_req.tbl_id);
    assign can_emit  = !r_out_valid || i_out_ready;
    assign victim_wb = d_valid && d_dirty;
    assign in_eval   = (r_state == ST_LK_EV) || (r_state == ST_SW_EV) || (r_state == ST_UN_EV);

    // Load the output register: writeback of a victim or of a closed frame, or the final word.
    assign out_push = ((r_state == ST_SW_EV) && (d_pins == '0) && !d_ref && victim_wb
                       && can_emit) ||
                      ((r_state == ST_CL_EV) && close_hit && d_dirty && can_emit) ||
                      ((r_state == ST_RESP) && can_emit);

    // Advance the hand, wrapping at the sweep size (also when it sits outside).
    assign b_inc  = {1'b0, r_b} + (FW+1)'(1);
    assign b_next = (b_inc >= (FW+1)'(r_cap)) ? '0 : b_inc[FW-1:0];

    logic [CW-1:0] cap_now;
    always_comb begin
        if (r_fiu == '0) begin
            cap_now = CW'(1);
        end else if (32'(r_fiu) > NUM_FRAMES) begin
            cap_now = CW'(NUM_FRAMES);
        end else begin
            cap_now = CW'(r_fiu);
        end
    end

    logic                w_dirty;
    logic                w_ref;
    logic [PIN_BITS-1:0] w_pins;
    logic [3:0]          w_table;
    logic [31:0]         w_page;

    // Read-modify-write control; reads and writes never overlap on one frame.
    always_comb begin
        ram_re    = 1'b0;
        ram_raddr = r_idx;
        ram_we    = 1'b0;
        ram_waddr = r_addr;
        w_table   = d_table;
        w_page    = d_page;
        w_dirty   = d_dirty;
        w_ref     = d_ref;
        w_pins    = d_pins;
        unique case (r_state)
            ST_LK_RD, ST_CL_RD: begin
                ram_re = 1'b1;
            end
            ST_UN_RD: begin
                ram_re    = 1'b1;
                ram_raddr = FW'(r_req.frame_index);
            end
            ST_SW_RD: begin
                ram_re    = (r_steps != (SW'(r_cap) << 1));
                ram_raddr = b_next;
            end
            ST_LK_EV: begin
                if (tag_match && (d_pins != '1)) begin
                    ram_we = 1'b1;
                    w_ref  = 1'b1;
                    w_pins = d_pins + PIN_BITS'(1);
                end
            end
            ST_SW_EV: begin
                if (d_pins == '0) begin
                    if (d_ref) begin
                        ram_we = 1'b1;
                        w_ref  = 1'b0;
                    end else if (!victim_wb || can_emit) begin
                        ram_we  = 1'b1;
                        w_table = r_req.tbl_id;
                        w_page  = r_req.page_addr;
                        w_dirty = 1'b0;
                        w_ref   = 1'b1;
                        w_pins  = PIN_BITS'(1);
                    end
                end
            end
            ST_UN_EV: begin
                if (d_pins != '0) begin
                    ram_we  = 1'b1;
                    w_pins  = d_pins - PIN_BITS'(1);
                    w_dirty = d_dirty | r_req.mark_dirty;
                end
            end
            default: begin
            end
        endcase
        ram_wdata = {w_table, w_page, w_dirty, w_ref, w_pins};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_hand      <= '0;
            r_fiu       <= CFW'(NUM_FRAMES);
            for (int i = 0; i < NUM_FRAMES; i++) begin
                r_fv[i] <= 1'b0;
            end
        end else begin
            if (i_cfg_valid) begin
                r_fiu <= CFW'(i_cfg_data);
            end
            // hold the output word until taken; a new load replaces it
            r_out_valid <= out_push || (r_out_valid && !i_out_ready);
            unique case (r_state)
                ST_IDLE: begin
                    if (i_in_valid) begin
                        r_req   <= i_in_data;
                        r_cap   <= cap_now;
                        r_idx   <= '0;
                        r_res   <= '{kind: K_ERR,
                                     frame: (i_in_data.cmd == CMD_UNPIN) ?
                                            i_in_data.frame_index : 4'd0,
                                     wb_table: i_in_data.tbl_id,
                                     wb_page: i_in_data.page_addr, last: 1'b1};
                        unique case (i_in_data.cmd)
                            CMD_PIN: begin
                                r_state <= (32'(i_in_data.tbl_id) >= NUM_TABLES) ?
                                           ST_RESP : ST_LK_RD;
                            end
                            CMD_CLOSE: begin
                                r_state <= (32'(i_in_data.tbl_id) >= NUM_TABLES) ?
                                           ST_RESP : ST_CL_RD;
                            end
                            CMD_UNPIN: begin
                                r_state <= (32'(i_in_data.frame_index) >= NUM_FRAMES) ?
                                           ST_RESP : ST_UN_RD;
                            end
                            default: begin
                                r_state <= ST_RESP;
                            end
                        endcase
                    end
                end
                ST_LK_RD: begin
                    r_addr  <= r_idx;
                    r_state <= ST_LK_EV;
                end
                ST_LK_EV: begin
                    if (tag_match) begin
                        r_res.kind  <= (d_pins == '1) ? K_ERR : K_HIT;
                        r_res.frame <= 4'(r_idx);
                        r_state     <= ST_RESP;
                    end else if (r_idx == FW'(NUM_FRAMES - 1)) begin
                        r_b     <= r_hand;
                        r_steps <= '0;
                        r_state <= ST_SW_RD;
                    end else begin
                        r_idx   <= r_idx + FW'(1);
                        r_state <= ST_LK_RD;
                    end
                end
                ST_SW_RD: begin
                    if (r_steps == (SW'(r_cap) << 1)) begin
                        r_res.kind <= K_NOVICTIM;
                        r_state    <= ST_RESP;
                    end else begin
                        r_b     <= b_next;
                        r_addr  <= b_next;
                        r_steps <= r_steps + SW'(1);
                        r_state <= ST_SW_EV;
                    end
                end
                ST_SW_EV: begin
                    if (d_pins != '0 || d_ref) begin
                        r_state <= ST_SW_RD;
                    end else if (!victim_wb || can_emit) begin
                        if (victim_wb) begin
                            r_out <= '{kind: K_WB, frame: 4'(r_b), wb_table: d_table,
                                       wb_page: d_page, last: 1'b0};
                        end
                        r_fv[r_b]   <= 1'b1;
                        r_hand      <= r_b;
                        r_res.kind  <= K_LOADED;
                        r_res.frame <= 4'(r_b);
                        r_state     <= ST_LOAD;
                    end
                end
                ST_LOAD: begin
                    r_state <= ST_RESP;
                end
                ST_CL_RD: begin
                    r_addr  <= r_idx;
                    r_state <= ST_CL_EV;
                end
                ST_CL_EV: begin
                    if (!(close_hit && d_dirty) || can_emit) begin
                        if (close_hit) begin
                            r_fv[r_idx] <= 1'b0;
                            if (d_dirty) begin
                                r_out <= '{kind: K_WB, frame: 4'(r_idx), wb_table: d_table,
                                           wb_page: d_page, last: 1'b0};
                            end
                        end
                        if (r_idx == FW'(NUM_FRAMES - 1)) begin
                            r_res.kind    <= K_CLOSED;
                            r_res.wb_page <= '0;
                            r_state       <= ST_RESP;
                        end else begin
                            r_idx   <= r_idx + FW'(1);
                            r_state <= ST_CL_RD;
                        end
                    end
                end
                ST_UN_RD: begin
                    r_addr  <= FW'(r_req.frame_index);
                    r_state <= ST_UN_EV;
                end
                ST_UN_EV: begin
                    if (d_pins != '0) begin
                        r_res.kind     <= K_UNPIN;
                        r_res.wb_table <= d_table;
                        r_res.wb_page  <= d_page;
                    end
                    r_state <= ST_RESP;
                end
                ST_RESP: begin
                    // hand over the closing word of the request
                    if (can_emit) begin
                        r_out   <= r_res;
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign o_cfg_ready = 1'b1;

    // RAM writes happen only while evaluating a frame that was just read.
    `CBPM_ASSERT(a_we_in_eval, ram_we |-> in_eval)
    // The sweep never evaluates a frame without having counted its step.
    `CBPM_ASSERT(a_sweep_counted, (r_state == ST_SW_EV) |-> (r_steps != '0))
    // A read and a write never target the RAM in the same cycle.
    `CBPM_NEVER(a_no_rw_overlap, ram_we && ram_re)
endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for the clock buffer pool manager top level.
module testbench;
    import cbpm_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_FRAMES = 16;
    localparam int PIN_MAX    = 255;
    localparam int WDOG_LIMIT = 20000;

    // Track expected result words in order and compare accepted words.
    class pool_scoreboard;
        t_out_word pending_q[$];
        int        mismatches;

        // Note one accepted request; the caller supplies its predicted words.
        function void note_request(t_out_word words[$]);
            foreach (words[k]) pending_q.push_back(words[k]);
        endfunction

        function void check_word(t_out_word got);
            t_out_word want;
            if (pending_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected word %h", got);
                return;
            end
            want = pending_q.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("mismatch: exp kind %0d fr %0d tb %0d pg %h last %0d",
                             want.kind, want.frame, want.wb_table, want.wb_page, want.last);
                    $display("          got kind %0d fr %0d tb %0d pg %h last %0d",
                             got.kind, got.frame, got.wb_table, got.wb_page, got.last);
                end
            end
        endfunction
    endclass

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_ready;
    t_in_word  i_in_data = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out_word o_out_data;
    logic      i_cfg_valid = 1'b0;
    logic      o_cfg_ready;
    logic [4:0] i_cfg_data = '0;

    always #10 i_clk = ~i_clk;

    clock_buffer_pool_manager_top DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out_data(o_out_data),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data)
    );

    // Shadow of the frame table.
    logic        pool_valid [NUM_FRAMES];
    logic [3:0]  pool_table [NUM_FRAMES];
    logic [31:0] pool_page  [NUM_FRAMES];
    logic        pool_dirty [NUM_FRAMES];
    logic        pool_ref   [NUM_FRAMES];
    int          pool_pins  [NUM_FRAMES];
    int          hand;
    logic [4:0]  sweep_cfg;

    pool_scoreboard sb;
    int  send_idle_pct;
    int  recv_stall_pct;
    int  idle_cycles;
    bit  timed_out;

    function automatic t_out_word mk(logic [2:0] k, int fr, logic [3:0] tb,
                                     logic [31:0] pg);
        t_out_word w;
        w.kind = k; w.frame = fr[3:0]; w.wb_table = tb; w.wb_page = pg; w.last = 1'b0;
        return w;
    endfunction

    // Work out the result words that one request causes and update the shadow.
    function automatic void predict_pool(t_in_word req, ref t_out_word words[$]);
        int cap, b, fi;
        bit done;
        words = {};
        done = 0;
        fi = req.frame_index;
        case (req.cmd)
            CMD_PIN: begin
                for (int i = 0; i < NUM_FRAMES && !done; i++)
                    if (pool_valid[i] && pool_table[i] == req.tbl_id &&
                        pool_page[i] == req.page_addr) begin
                        done = 1;
                        if (pool_pins[i] >= PIN_MAX)
                            words.push_back(mk(K_ERR, i, req.tbl_id, req.page_addr));
                        else begin
                            pool_ref[i] = 1; pool_pins[i]++;
                            words.push_back(mk(K_HIT, i, req.tbl_id, req.page_addr));
                        end
                    end
                if (!done) begin
                    cap = (sweep_cfg == 0) ? 1 : (sweep_cfg > NUM_FRAMES) ? NUM_FRAMES
                                                                           : sweep_cfg;
                    b = hand;
                    for (int s = 0; s < 2 * cap && !done; s++) begin
                        b++;
                        if (b >= cap) b = 0;
                        if (pool_pins[b] != 0) continue;
                        if (pool_ref[b]) begin
                            pool_ref[b] = 0;
                            continue;
                        end
                        if (pool_valid[b] && pool_dirty[b])
                            words.push_back(mk(K_WB, b, pool_table[b], pool_page[b]));
                        pool_valid[b] = 1; pool_table[b] = req.tbl_id;
                        pool_page[b] = req.page_addr; pool_dirty[b] = 0;
                        pool_ref[b] = 1; pool_pins[b] = 1; hand = b;
                        words.push_back(mk(K_LOADED, b, req.tbl_id, req.page_addr));
                        done = 1;
                    end
                    if (!done)
                        words.push_back(mk(K_NOVICTIM, 0, req.tbl_id, req.page_addr));
                end
            end
            CMD_UNPIN: begin
                if (pool_pins[fi] == 0)
                    words.push_back(mk(K_ERR, fi, req.tbl_id, req.page_addr));
                else begin
                    pool_pins[fi]--;
                    if (req.mark_dirty) pool_dirty[fi] = 1;
                    words.push_back(mk(K_UNPIN, fi, pool_table[fi], pool_page[fi]));
                end
            end
            CMD_CLOSE: begin
                for (int i = 0; i < NUM_FRAMES; i++)
                    if (pool_valid[i] && pool_table[i] == req.tbl_id) begin
                        if (pool_dirty[i])
                            words.push_back(mk(K_WB, i, pool_table[i], pool_page[i]));
                        pool_valid[i] = 0; pool_table[i] = 0; pool_page[i] = 0;
                        pool_dirty[i] = 0; pool_ref[i] = 0; pool_pins[i] = 0;
                    end
                words.push_back(mk(K_CLOSED, 0, req.tbl_id, 32'd0));
            end
            default: words.push_back(mk(K_ERR, 0, req.tbl_id, req.page_addr));
        endcase
        words[words.size() - 1].last = 1'b1;
    endfunction

    // Receiver: stall at random, check each accepted word.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) sb.check_word(o_out_data);
            i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog: count cycles without any accepted word.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_LIMIT) begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    // Present one request word and record its prediction once accepted.
    // Valid stays high after acceptance; a drain, or the next call when it idles, drops it.
    task automatic send_request(t_in_word req);
        t_out_word words[$];
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= req;
        do @(posedge i_clk); while (!o_in_ready);
        predict_pool(req, words);
        sb.note_request(words);
    endtask

    // Wait until every expected word has come, then let the block settle.
    task automatic drain_pool();
        i_in_valid <= 1'b0;
        while (sb.pending_q.size() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    task automatic write_sweep_size(logic [4:0] value);
        drain_pool();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        sweep_cfg = value;
        i_cfg_valid <= 1'b0;
    endtask

    function automatic t_in_word make_req(logic [1:0] c, int tb, logic [31:0] pg,
                                          int fi, int md);
        t_in_word r;
        r.cmd = c; r.tbl_id = tb[3:0]; r.page_addr = pg; r.frame_index = fi[3:0];
        r.mark_dirty = md[0];
        return r;
    endfunction

    // Mostly pins of a small page set and unpins of random frames; some closes and noise.
    function automatic t_in_word random_req();
        int sel;
        sel = $urandom_range(99);
        if (sel < 50)
            return make_req(CMD_PIN, $urandom_range(3), $urandom_range(11), 0, 0);
        if (sel < 80)
            return make_req(CMD_UNPIN, $urandom, $urandom, $urandom_range(15),
                            $urandom_range(1));
        if (sel < 88)
            return make_req(CMD_CLOSE, $urandom_range(3), $urandom, $urandom, $urandom);
        if (sel < 95)
            return make_req(CMD_PIN, $urandom, $urandom, $urandom, $urandom);
        return make_req(2'd3, $urandom, $urandom, $urandom, $urandom);
    endfunction

    initial begin
        sb = new();
        send_idle_pct = 0; recv_stall_pct = 0; idle_cycles = 0;
        for (int i = 0; i < NUM_FRAMES; i++) begin
            pool_valid[i] = 0; pool_table[i] = 0; pool_page[i] = 0;
            pool_dirty[i] = 0; pool_ref[i] = 0; pool_pins[i] = 0;
        end
        hand = 0;
        sweep_cfg = 5'd16;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: extremes of fields, every command, each corner.
        send_request(make_req(CMD_UNPIN, 4'hF, 32'hFFFF_FFFF, 4'hF, 1)); // underflow
        send_request(make_req(CMD_PIN, 4'h0, 32'h0, 0, 0));
        send_request(make_req(CMD_PIN, 4'hF, 32'hFFFF_FFFF, 4'hF, 1));
        send_request(make_req(CMD_PIN, 4'h0, 32'h0, 0, 0));                // hit
        send_request(make_req(CMD_UNPIN, 0, 0, 4'd1, 1));
        send_request(make_req(CMD_UNPIN, 0, 0, 4'd1, 0));
        send_request(make_req(CMD_UNPIN, 0, 0, 4'd2, 1));
        send_request(make_req(2'd3, 4'h5, 32'h1234_5678, 4'h3, 1));        // bad cmd
        send_request(make_req(CMD_CLOSE, 4'h0, 32'hFFFF_FFFF, 4'hF, 1));   // flush dirty
        send_request(make_req(CMD_CLOSE, 4'h9, 32'h0, 0, 0));              // empty close

        // Tiny sweep: out-of-range values, hand outside range, no victim.
        write_sweep_size(5'd0);
        send_request(make_req(CMD_PIN, 4'h1, 32'h10, 0, 0));
        send_request(make_req(CMD_PIN, 4'h1, 32'h11, 0, 0));               // no victim
        write_sweep_size(5'd31);
        send_request(make_req(CMD_PIN, 4'h1, 32'h12, 0, 0));
        write_sweep_size(5'd1);
        send_request(make_req(CMD_PIN, 4'h1, 32'h13, 0, 0));               // hand reset
        send_request(make_req(CMD_CLOSE, 4'h1, 0, 0, 0));                  // pinned close
        send_request(make_req(CMD_CLOSE, 4'h7, 0, 0, 0));

        // Random phases over several sweep sizes and idling patterns.
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin write_sweep_size(5'd16); send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin write_sweep_size(5'd4);  send_idle_pct = 70; recv_stall_pct = 0;  end
                2: begin write_sweep_size(5'd2);  send_idle_pct = 0;  recv_stall_pct = 70; end
                default: begin
                    write_sweep_size(5'd9); send_idle_pct = 8; recv_stall_pct = 8;
                end
            endcase
            for (int n = 0; n < 22; n++) send_request(random_req());
        end

        drain_pool();
        if (sb.mismatches == 0 && sb.pending_q.size() == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end
endmodule
